>>> sv/cts_pkg.sv
package cts_pkg;

    localparam int MAX_TERMS  = 16;
    localparam int COEF_DEPTH = 4096;
    localparam int TW         = $clog2(MAX_TERMS);
    localparam int AW         = $clog2(COEF_DEPTH);
    // narrow basis values (T_n, 2*xi) and wide ones (scaled derivatives, weights)
    localparam int SW         = 20;
    localparam int BW         = 40;
    localparam int ONE_Q16    = 65536;
    localparam int HALF_Q16   = 32768;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [1:0] CFG_DERIV  = 2'd3;

    typedef struct packed {
        logic        is_eval;
        logic [11:0] index;
        logic [31:0] value;
        logic [16:0] cu;
        logic [16:0] cv;
        logic [16:0] cw;
    } cmd_t;

    typedef struct packed {
        logic [4:0] size_x;
        logic [4:0] size_y;
        logic [4:0] size_z;
        logic       second;
    } cfg_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [31:0]   wdata;
        logic [AW-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic eval_busy;
        logic mac_active;
    } back_stat_t;

    // round a product to q16: add half, floor shift
    function automatic logic signed [BW-1:0] rmul_ts(input logic signed [BW-1:0] a,
                                                      input logic signed [SW-1:0] b);
        logic signed [BW+SW-1:0] p;
        begin
            p = a * b + $signed((BW+SW)'(HALF_Q16));
            return p[BW+15:16];
        end
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        begin
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
            begin
                return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            return s;
        end
    endfunction

endpackage

>>> sv/cts_ram.sv
module cts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/cts_front.sv
module cts_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [95:0]         s_tdata,
    input  logic                s_tuser,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cts_pkg::cmd_t       cmd
);

    localparam int QD = 2;
    localparam int PW = $clog2(QD);

    cts_pkg::cmd_t   q_reg [QD];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;
    cts_pkg::cmd_t   in_cmd;
    logic            push, pop;

    function automatic logic [16:0] clamp_coord(input logic [16:0] c);
        begin
            return (c > 17'(cts_pkg::ONE_Q16)) ? 17'(cts_pkg::ONE_Q16) : c;
        end
    endfunction

    always_comb
    begin
        in_cmd.is_eval = (s_tuser == cts_pkg::FUNC_EVAL);
        in_cmd.index   = s_tdata[11:0];
        in_cmd.value   = s_tdata[43:12];
        in_cmd.cu      = clamp_coord(s_tdata[60:44]);
        in_cmd.cv      = clamp_coord(s_tdata[77:61]);
        in_cmd.cw      = clamp_coord(s_tdata[94:78]);
    end

    assign s_tready  = (count_reg != (PW+1)'(QD));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> sv/cts_basis.sv
module cts_basis (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [16:0]                         coord,
    input  logic                                second,
    output logic                                busy,
    output logic signed [cts_pkg::SW-1:0]       t_tab [cts_pkg::MAX_TERMS],
    output logic signed [cts_pkg::BW-1:0]       d_tab [cts_pkg::MAX_TERMS]
);

    localparam int SW = cts_pkg::SW;
    localparam int BW = cts_pkg::BW;
    localparam int TW = cts_pkg::TW;

    logic                 busy_reg;
    logic [TW-1:0]        step_reg;
    logic                 second_reg;
    logic signed [SW-1:0] x2_reg;
    logic signed [SW-1:0] t_cur_reg, t_prev_reg;
    logic signed [BW-1:0] tp_cur_reg, tp_prev_reg, tpp_cur_reg, tpp_prev_reg;
    logic signed [SW-1:0] t_tab_reg [cts_pkg::MAX_TERMS];
    logic signed [BW-1:0] d_tab_reg [cts_pkg::MAX_TERMS];

    logic signed [SW-1:0] xi;
    logic signed [BW-1:0] t_wide, t_next_w, tp_next, tpp_next, d_next;

    assign xi = $signed({2'b00, coord, 1'b0}) - SW'(cts_pkg::ONE_Q16);

    always_comb
    begin
        t_wide   = BW'(t_cur_reg);
        t_next_w = cts_pkg::rmul_ts(t_wide, x2_reg) - BW'(t_prev_reg);
        tp_next  = (t_wide <<< 1) + cts_pkg::rmul_ts(tp_cur_reg, x2_reg) - tp_prev_reg;
        tpp_next = (tp_cur_reg <<< 2) + cts_pkg::rmul_ts(tpp_cur_reg, x2_reg) - tpp_prev_reg;
        d_next   = second_reg ? (tpp_next <<< 2) : (tp_next <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= TW'(1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == TW'(cts_pkg::MAX_TERMS - 2))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            second_reg   <= second;
            x2_reg       <= xi <<< 1;
            t_prev_reg   <= SW'(cts_pkg::ONE_Q16);
            t_cur_reg    <= xi;
            tp_prev_reg  <= '0;
            tp_cur_reg   <= BW'(cts_pkg::ONE_Q16);
            tpp_prev_reg <= '0;
            tpp_cur_reg  <= '0;
            t_tab_reg[0] <= SW'(cts_pkg::ONE_Q16);
            t_tab_reg[1] <= xi;
            d_tab_reg[0] <= '0;
            d_tab_reg[1] <= second ? BW'(0) : BW'(2 * cts_pkg::ONE_Q16);
        end
        else if (busy_reg)
        begin
            t_prev_reg   <= t_cur_reg;
            t_cur_reg    <= t_next_w[SW-1:0];
            tp_prev_reg  <= tp_cur_reg;
            tp_cur_reg   <= tp_next;
            tpp_prev_reg <= tpp_cur_reg;
            tpp_cur_reg  <= tpp_next;
            t_tab_reg[step_reg + 1'b1] <= t_next_w[SW-1:0];
            d_tab_reg[step_reg + 1'b1] <= d_next;
        end
    end

    assign busy  = busy_reg;
    assign t_tab = t_tab_reg;
    assign d_tab = d_tab_reg;

endmodule

>>> sv/cts_back.sv
module cts_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cts_pkg::cfg_t         cfg,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cts_pkg::cmd_t         cmd,
    output cts_pkg::ram_req_t     ram_req,
    input  logic [31:0]           ram_rdata,
    output cts_pkg::back_stat_t   stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [255:0]          m_tdata
);

    localparam int SW = cts_pkg::SW;
    localparam int BW = cts_pkg::BW;
    localparam int TW = cts_pkg::TW;
    localparam int AW = cts_pkg::AW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASIS,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t          state_reg;
    logic            start_reg;
    logic [16:0]     cu_reg, cv_reg, cw_reg;
    logic [4:0]      sx_reg, sy_reg, sz_reg;
    logic [TW-1:0]   i_reg, j_reg, k_reg;
    logic [AW-1:0]   addr_reg;
    logic            out_valid_reg;
    logic [255:0]    out_data_reg;
    logic [4:0]      vld_reg;
    logic            acc_clear;

    logic [4:0]      sx_c, sy_c, sz_c;
    logic            issue, last_term, bx_busy, by_busy, bz_busy;

    logic signed [SW-1:0] tx_tab [cts_pkg::MAX_TERMS];
    logic signed [SW-1:0] ty_tab [cts_pkg::MAX_TERMS];
    logic signed [SW-1:0] tz_tab [cts_pkg::MAX_TERMS];
    logic signed [BW-1:0] dx_tab [cts_pkg::MAX_TERMS];
    logic signed [BW-1:0] dy_tab [cts_pkg::MAX_TERMS];
    logic signed [BW-1:0] dz_tab [cts_pkg::MAX_TERMS];

    // term pipeline
    logic signed [SW-1:0] tx1_reg, ty1_reg, tz1_reg;
    logic signed [BW-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [SW-1:0] m_tt_reg, tz2_reg;
    logic signed [BW-1:0] m_dt_reg, m_td_reg, dz2_reg;
    logic signed [31:0]   c2_reg, c3_reg;
    logic signed [BW-1:0] w_reg [4];
    logic signed [55:0]   hi_reg [4];
    logic signed [48:0]   lo_reg [4];
    logic signed [63:0]   term_reg [4];
    logic signed [63:0]   acc_reg [4];
    logic signed [BW-1:0] m_tt_w;

    cts_basis u_basis_x (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .coord(cu_reg), .second(cfg.second),
        .busy(bx_busy), .t_tab(tx_tab), .d_tab(dx_tab)
    );
    cts_basis u_basis_y (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .coord(cv_reg), .second(cfg.second),
        .busy(by_busy), .t_tab(ty_tab), .d_tab(dy_tab)
    );
    cts_basis u_basis_z (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .coord(cw_reg), .second(cfg.second),
        .busy(bz_busy), .t_tab(tz_tab), .d_tab(dz_tab)
    );

    always_comb
    begin
        sx_c = (cfg.size_x > 5'(cts_pkg::MAX_TERMS)) ? 5'(cts_pkg::MAX_TERMS) : cfg.size_x;
        sy_c = (cfg.size_y > 5'(cts_pkg::MAX_TERMS)) ? 5'(cts_pkg::MAX_TERMS) :
               (cfg.size_y == 5'd0) ? 5'd1 : cfg.size_y;
        sz_c = (cfg.size_z > 5'(cts_pkg::MAX_TERMS)) ? 5'(cts_pkg::MAX_TERMS) :
               (cfg.size_z == 5'd0) ? 5'd1 : cfg.size_z;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign issue     = (state_reg == ST_MAC);
    assign last_term = ({1'b0, i_reg} == sx_reg - 5'd1) && ({1'b0, j_reg} == sy_reg - 5'd1)
                       && ({1'b0, k_reg} == sz_reg - 5'd1);
    assign acc_clear = (state_reg == ST_IDLE) && cmd_valid && cmd.is_eval;

    always_comb
    begin
        ram_req.we    = (state_reg == ST_IDLE) && cmd_valid && !cmd.is_eval;
        ram_req.waddr = cmd.index[AW-1:0];
        ram_req.wdata = cmd.value;
        ram_req.raddr = addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            addr_reg      <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && m_tready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && cmd.is_eval)
                    begin
                        cu_reg   <= cmd.cu;
                        cv_reg   <= cmd.cv;
                        cw_reg   <= cmd.cw;
                        sx_reg   <= sx_c;
                        sy_reg   <= sy_c;
                        sz_reg   <= sz_c;
                        i_reg    <= '0;
                        j_reg    <= '0;
                        k_reg    <= '0;
                        addr_reg <= '0;
                        if (sx_c == 5'd0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                            state_reg <= ST_BASIS;
                        end
                    end
                end
                ST_BASIS:
                begin
                    if (!start_reg && !bx_busy && !by_busy && !bz_busy)
                    begin
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (last_term)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else if ({1'b0, i_reg} != sx_reg - 5'd1)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        i_reg <= '0;
                        if ({1'b0, j_reg} != sy_reg - 5'd1)
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                        else
                        begin
                            j_reg <= '0;
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (vld_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {acc_reg[3], acc_reg[2], acc_reg[1], acc_reg[0]};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], issue};
        end
    end

    assign m_tt_w = BW'(m_tt_reg);

    always_ff @(posedge clk)
    begin
        // stage 1: basis lookups, aligned with the ram read
        tx1_reg <= tx_tab[i_reg];
        dx1_reg <= dx_tab[i_reg];
        ty1_reg <= ty_tab[j_reg];
        dy1_reg <= dy_tab[j_reg];
        tz1_reg <= tz_tab[k_reg];
        dz1_reg <= dz_tab[k_reg];
        // stage 2: xy products
        m_tt_reg <= SW'(cts_pkg::rmul_ts(BW'(tx1_reg), ty1_reg));
        m_dt_reg <= cts_pkg::rmul_ts(dx1_reg, ty1_reg);
        m_td_reg <= cts_pkg::rmul_ts(dy1_reg, tx1_reg);
        tz2_reg  <= tz1_reg;
        dz2_reg  <= dz1_reg;
        c2_reg   <= ram_rdata;
        // stage 3: weights for value, d/du, d/dv, d/dw
        w_reg[0] <= cts_pkg::rmul_ts(m_tt_w, tz2_reg);
        w_reg[1] <= cts_pkg::rmul_ts(m_dt_reg, tz2_reg);
        w_reg[2] <= cts_pkg::rmul_ts(m_td_reg, tz2_reg);
        w_reg[3] <= cts_pkg::rmul_ts(dz2_reg, m_tt_reg);
        c3_reg   <= c2_reg;
        // stage 4 and 5: coef times weight, split at the binary point
        for (int n = 0; n < 4; n++)
        begin
            hi_reg[n]   <= c3_reg * $signed(w_reg[n][BW-1:16]);
            lo_reg[n]   <= c3_reg * $signed({1'b0, w_reg[n][15:0]});
            term_reg[n] <= {{8{hi_reg[n][55]}}, hi_reg[n]}
                           + 64'((lo_reg[n] + 49'sd32768) >>> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 4; n++)
        begin
            if (acc_clear)
            begin
                acc_reg[n] <= '0;
            end
            else if (vld_reg[4])
            begin
                acc_reg[n] <= cts_pkg::sat_add64(acc_reg[n], term_reg[n]);
            end
        end
    end

    assign stat.eval_busy  = (state_reg != ST_IDLE);
    assign stat.mac_active = (state_reg == ST_MAC) || (vld_reg != '0);
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule

>>> sv/chebyshev_tensor_series_eval.sv
// Evaluates a 2D or 3D tensor-product Chebyshev series held in a 4096-word coefficient
// store. A write transaction (tuser 0) stores one coefficient through the execution
// side. An evaluate transaction (tuser 1) first builds the three basis tables in
// parallel recurrence units, then passes one coefficient per cycle through a six-stage
// multiply-accumulate pipeline, with each coefficient fetched in turn from the single
// store read port, which sets the rate. A two-entry command queue lets new transactions
// enter while an evaluation runs, and a finished result waits in the output register
// without stalling the next evaluation's work. Coefficients must be written before use.
module chebyshev_tensor_series_eval (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // coef_index, coef_value, coord_u, coord_v, coord_w
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata,   // series_value, deriv_u, deriv_v, deriv_w
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data
);

    cts_pkg::cfg_t       cfg_reg;
    cts_pkg::cmd_t       cmd;
    cts_pkg::ram_req_t   ram_req;
    cts_pkg::back_stat_t stat;
    logic                cmd_valid, cmd_ready;
    logic [31:0]         ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_x <= 5'd1;
            cfg_reg.size_y <= 5'd1;
            cfg_reg.size_z <= 5'd1;
            cfg_reg.second <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cts_pkg::CFG_SIZE_X: cfg_reg.size_x <= cfg_data;
                cts_pkg::CFG_SIZE_Y: cfg_reg.size_y <= cfg_data;
                cts_pkg::CFG_SIZE_Z: cfg_reg.size_z <= cfg_data;
                cts_pkg::CFG_DERIV:  cfg_reg.second <= cfg_data[0];
                default:             cfg_reg.second <= cfg_reg.second;
            endcase
        end
    end

    cts_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    cts_ram #(
        .WIDTH(32),
        .DEPTH(cts_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .clk(clk), .we(ram_req.we), .waddr(ram_req.waddr), .wdata(ram_req.wdata),
        .raddr(ram_req.raddr), .rdata(ram_rdata)
    );

    cts_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .ram_req(ram_req), .ram_rdata(ram_rdata), .stat(stat),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // store is never written while an evaluation is in flight
    assert property (@(posedge clk) disable iff (!rst_n) stat.eval_busy |-> !ram_req.we)
        else $error("coefficient write during evaluation");

    // a full front queue always has a command for the execution side
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> cmd_valid)
        else $error("input stalled with empty queue");

    // a new result only comes out of a running evaluation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(stat.eval_busy) && !$past(stat.mac_active))
        else $error("result without finished evaluation");

endmodule

>>> sim/cts_series_checker.sv
`timescale 1ns / 100ps

module cts_series_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,   // coef_index, coef_value, coord_u, coord_v, coord_w
    input  logic         s_tuser,   // func
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [255:0] m_tdata,   // series_value, deriv_u, deriv_v, deriv_w
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data,
    output int           errors,
    output int           pending,
    output int           results_seen
);

    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = -I64_MAX - 1;

    typedef struct {
        longint value;
        longint du;
        longint dv;
        longint dw;
    } series_result_t;

    logic [31:0]    coef_mem [cts_pkg::COEF_DEPTH];
    logic [4:0]     terms_x;
    logic [4:0]     terms_y;
    logic [4:0]     terms_z;
    logic           second_order;
    series_result_t expected_q [$];

    function automatic longint round_q16(input longint a, input longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic longint sat_sum(input longint a, input longint b);
        if (b > 0 && a > I64_MAX - b)
            return I64_MAX;
        if (b < 0 && a < I64_MIN - b)
            return I64_MIN;
        return a + b;
    endfunction

    // coefficient times weight with the weight split so nothing overflows
    function automatic longint weighted_coef(input longint c, input longint w);
        longint wh;
        longint wl;
        wh = w >>> 16;
        wl = w - wh * 65536;
        return c * wh + ((c * wl + 32768) >>> 16);
    endfunction

    function automatic void chebyshev_basis(input longint coord, input int n, input bit second,
                                            output longint t[cts_pkg::MAX_TERMS],
                                            output longint d[cts_pkg::MAX_TERMS]);
        longint tp [cts_pkg::MAX_TERMS];
        longint tpp [cts_pkg::MAX_TERMS];
        longint xi;
        longint x2;
        for (int m = 0; m < cts_pkg::MAX_TERMS; m++)
        begin
            t[m] = 0;
            tp[m] = 0;
            tpp[m] = 0;
        end
        if (coord > cts_pkg::ONE_Q16)
            coord = cts_pkg::ONE_Q16;
        xi = 2 * coord - cts_pkg::ONE_Q16;
        x2 = 2 * xi;
        t[0] = cts_pkg::ONE_Q16;
        if (n > 1)
        begin
            t[1] = xi;
            tp[1] = cts_pkg::ONE_Q16;
        end
        for (int m = 1; m + 1 < n; m++)
        begin
            t[m+1]   = round_q16(x2, t[m]) - t[m-1];
            tp[m+1]  = 2 * t[m] + round_q16(x2, tp[m]) - tp[m-1];
            tpp[m+1] = 4 * tp[m] + round_q16(x2, tpp[m]) - tpp[m-1];
        end
        for (int m = 0; m < cts_pkg::MAX_TERMS; m++)
            d[m] = second ? 4 * tpp[m] : 2 * tp[m];
    endfunction

    function automatic series_result_t eval_series(input longint cu, input longint cv,
                                                   input longint cw);
        series_result_t r;
        longint tx [cts_pkg::MAX_TERMS];
        longint dx [cts_pkg::MAX_TERMS];
        longint ty [cts_pkg::MAX_TERMS];
        longint dy [cts_pkg::MAX_TERMS];
        longint tz [cts_pkg::MAX_TERMS];
        longint dz [cts_pkg::MAX_TERMS];
        int     sx;
        int     sy;
        int     sz;
        int     addr;
        longint c;
        bit     solid;
        r = '{0, 0, 0, 0};
        sx = terms_x > cts_pkg::MAX_TERMS ? cts_pkg::MAX_TERMS : terms_x;
        sy = terms_y == 0 ? 1 : (terms_y > cts_pkg::MAX_TERMS ? cts_pkg::MAX_TERMS : terms_y);
        sz = terms_z == 0 ? 1 : (terms_z > cts_pkg::MAX_TERMS ? cts_pkg::MAX_TERMS : terms_z);
        solid = sz > 1;
        if (sx == 0)
            return r;
        chebyshev_basis(cu, sx, second_order, tx, dx);
        chebyshev_basis(cv, sy, second_order, ty, dy);
        if (solid)
            chebyshev_basis(cw, sz, second_order, tz, dz);
        else
        begin
            tz[0] = cts_pkg::ONE_Q16;
            dz[0] = 0;
        end
        for (int k = 0; k < sz; k++)
            for (int j = 0; j < sy; j++)
                for (int i = 0; i < sx; i++)
                begin
                    addr = i + sx * (j + sy * k);
                    if (addr < cts_pkg::COEF_DEPTH)
                    begin
                        c = longint'($signed(coef_mem[addr]));
                        r.value = sat_sum(r.value, weighted_coef(c,
                            round_q16(round_q16(tx[i], ty[j]), tz[k])));
                        r.du = sat_sum(r.du, weighted_coef(c,
                            round_q16(round_q16(dx[i], ty[j]), tz[k])));
                        r.dv = sat_sum(r.dv, weighted_coef(c,
                            round_q16(round_q16(tx[i], dy[j]), tz[k])));
                        if (solid)
                            r.dw = sat_sum(r.dw, weighted_coef(c,
                                round_q16(round_q16(tx[i], ty[j]), dz[k])));
                    end
                end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        results_seen = 0;
        terms_x = 5'd1;
        terms_y = 5'd1;
        terms_z = 5'd1;
        second_order = 1'b0;
    end

    always @(posedge clk)
    begin
        series_result_t want;
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                cts_pkg::CFG_SIZE_X: terms_x = cfg_data;
                cts_pkg::CFG_SIZE_Y: terms_y = cfg_data;
                cts_pkg::CFG_SIZE_Z: terms_z = cfg_data;
                cts_pkg::CFG_DERIV:  second_order = cfg_data[0];
                default:             second_order = second_order;
            endcase
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            if (s_tuser == cts_pkg::FUNC_WRITE)
                coef_mem[s_tdata[11:0]] = s_tdata[43:12];
            else
                expected_q.push_back(eval_series(s_tdata[60:44], s_tdata[77:61],
                                                 s_tdata[94:78]));
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t ns: result transaction with nothing expected", $time);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if ($signed(m_tdata[63:0]) != want.value)
                    report_mismatch("series_value", m_tdata[63:0], want.value);
                if ($signed(m_tdata[127:64]) != want.du)
                    report_mismatch("deriv_u", m_tdata[127:64], want.du);
                if ($signed(m_tdata[191:128]) != want.dv)
                    report_mismatch("deriv_v", m_tdata[191:128], want.dv);
                if ($signed(m_tdata[255:192]) != want.dw)
                    report_mismatch("deriv_w", m_tdata[255:192], want.dw);
            end
        end
        pending = expected_q.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 40000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // coef_index, coef_value, coord_u, coord_v, coord_w
    logic         s_tuser;   // func
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;   // series_value, deriv_u, deriv_v, deriv_w
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [4:0]   cfg_data;

    int errors;
    int pending;
    int results_seen;
    int send_idle;
    int recv_idle;
    int hold_cycles;
    int idle_count;
    int writes_sent;
    int evals_sent;
    int region;
    bit written [cts_pkg::COEF_DEPTH];

    chebyshev_tensor_series_eval dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cts_series_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random backpressure, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("chebyshev_tensor_series_eval test failed");
            $finish;
        end
    end

    task automatic send_item(input logic func, input logic [11:0] idx, input logic [31:0] val,
                             input logic [16:0] cu, input logic [16:0] cv,
                             input logic [16:0] cw);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {1'b0, cw, cv, cu, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (func == cts_pkg::FUNC_WRITE)
        begin
            written[idx] = 1'b1;
            writes_sent++;
        end
        else
            evals_sent++;
    endtask

    task automatic write_coef(input int idx, input logic [31:0] val);
        send_item(cts_pkg::FUNC_WRITE, idx[11:0], val, 17'($urandom), 17'($urandom),
                  17'($urandom));
    endtask

    function automatic logic [16:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return 17'd0;
        if (sel < 16)
            return 17'd65536;
        if (sel < 24)
            return 17'($urandom);
        return 17'($urandom_range(65536));
    endfunction

    function automatic logic [31:0] pick_coef();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return 32'h8000_0000;
        if (sel < 10)
            return 32'h7FFF_FFFF;
        if (sel < 55)
            return 32'($signed($urandom_range(262144)) - 131072);
        return $urandom;
    endfunction

    task automatic evaluate_at(input logic [16:0] cu, input logic [16:0] cv,
                               input logic [16:0] cw);
        send_item(cts_pkg::FUNC_EVAL, 12'($urandom), $urandom, cu, cv, cw);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // writes may still be in flight behind the last result
        repeat (100) @(negedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [4:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input int sx, input int sy, input int sz, input int order);
        int ex;
        int ey;
        int ez;
        wait_drained();
        set_reg(cts_pkg::CFG_SIZE_X, 5'(sx));
        set_reg(cts_pkg::CFG_SIZE_Y, 5'(sy));
        set_reg(cts_pkg::CFG_SIZE_Z, 5'(sz));
        set_reg(cts_pkg::CFG_DERIV, 5'(order));
        ex = sx > cts_pkg::MAX_TERMS ? cts_pkg::MAX_TERMS : sx;
        ey = sy == 0 ? 1 : (sy > cts_pkg::MAX_TERMS ? cts_pkg::MAX_TERMS : sy);
        ez = sz == 0 ? 1 : (sz > cts_pkg::MAX_TERMS ? cts_pkg::MAX_TERMS : sz);
        region = ex * ey * ez;
        // every coefficient the series can touch gets a value first
        for (int a = 0; a < region; a++)
            if (!written[a])
                write_coef(a, pick_coef());
    endtask

    task automatic random_items(input int count);
        int n;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(99) < 60)
                evaluate_at(pick_coord(), pick_coord(), pick_coord());
            else if ($urandom_range(99) < 80 && region > 0)
                write_coef($urandom_range(region - 1), pick_coef());
            else
                write_coef($urandom_range(cts_pkg::COEF_DEPTH - 1), pick_coef());
            n++;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = cts_pkg::FUNC_WRITE;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_index   = cts_pkg::CFG_SIZE_X;
        cfg_data    = '0;
        hold_cycles = 0;
        idle_count  = 0;
        writes_sent = 0;
        evals_sent  = 0;
        region      = 1;
        send_idle   = 23;
        recv_idle   = 61;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: one term, corner values and coordinates
        write_coef(0, 32'h7FFF_FFFF);
        evaluate_at(17'd0, 17'd0, 17'd0);
        write_coef(0, 32'h8000_0000);
        evaluate_at(17'd65536, 17'd65536, 17'd65536);
        write_coef(4095, 32'h8000_0000);
        write_coef(4095, 32'h7FFF_FFFF);
        write_coef(0, 32'h0001_0000);
        evaluate_at(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        evaluate_at(17'd32768, 17'd16384, 17'd49152);

        configure(16, 1, 1, 0);
        evaluate_at(17'd0, 17'd65536, 17'd0);
        evaluate_at(17'd65536, 17'd0, 17'd0);
        evaluate_at(17'h1FFFF, 17'd12345, 17'h1FFFF);
        random_items(8);

        configure(2, 3, 4, 1);
        evaluate_at(17'd0, 17'd65536, 17'd65536);
        evaluate_at(17'd65536, 17'd0, 17'd0);
        random_items(16);

        // zero terms along x: everything reads as zero
        configure(0, 5, 2, 0);
        random_items(5);

        send_idle = 61;
        recv_idle = 23;
        // oversize and zero sizes clamp
        configure(31, 0, 0, 1);
        random_items(12);

        configure(3, 2, 2, 0);
        random_items(10);
        // long receiver hold-off while evaluations keep coming
        hold_cycles = 3000;
        send_idle = 0;
        for (int e = 0; e < 8; e++)
            evaluate_at(pick_coord(), pick_coord(), pick_coord());
        send_idle = 61;
        random_items(10);

        send_idle = 0;
        recv_idle = 0;
        configure(4, 2, 3, 1);
        random_items(12);
        // sender pauses until every result is back
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        random_items(12);

        configure(2, 1, 16, 1);
        evaluate_at(17'd0, 17'd0, 17'd0);
        evaluate_at(17'd65536, 17'd65536, 17'd65536);
        evaluate_at(pick_coord(), pick_coord(), pick_coord());

        configure(5, 1, 3, 0);
        random_items(12);

        wait_drained();
        $display("covered %0d coefficient writes and %0d evaluations, %0d results checked",
                 writes_sent, evals_sent, results_seen);
        $display("sizes from 0 to 31 per axis, both derivative orders, 2D and 3D series");
        if (errors == 0 && pending == 0)
            $display("chebyshev_tensor_series_eval test passed");
        else
            $display("chebyshev_tensor_series_eval test failed");
        $finish;
    end

endmodule
